// ----- rtl/core/vtx_rfp_pkg.sv -----
// Shared types and constants for the reply frame parser.
// No dependencies; used by vtx_rfp_judge and vtx_reply_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

package vtx_rfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h0F;

  // configuration register indexes
  localparam logic [1:0] CFG_EXPECTED_CMD = 2'd0;
  localparam logic [1:0] CFG_RESET_CODE   = 2'd1;
  localparam logic [1:0] CFG_SETTINGS_CODE = 2'd2;
  localparam logic [1:0] CFG_TEMP_CODE    = 2'd3;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_VALID   = 2'd1,
    ST_ECHO    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] expected_cmd;
    logic [7:0] reset_code;
    logic [7:0] settings_code;
    logic [7:0] temp_code;
  } cfg_t;

  typedef struct packed {
    status_e status;
    logic    good;
  } verdict_t;

endpackage

`default_nettype wire

// ----- rtl/core/vtx_reply_frame_parser.sv -----
// Top level of the reply frame parser: phase tracking, frame store, result register.
// Depends on vtx_rfp_pkg and vtx_rfp_judge.
`timescale 1ns / 1ps
`default_nettype none

// Deframes fixed-length reply frames of FRAME_LEN bytes (sync 0x0F, command, data,
// checksum, end) from a stream of received bytes. Every accepted byte yields exactly
// one result word in the next cycle: the bytes-wanted hint, the frame status, and on
// the end byte the command and, for a valid frame, four little-endian payload words.
// One byte per cycle is sustained: the phase, the running 8-bit checksum and the
// byte store all update in a single pass, and the only stall is a result word
// still held in the output register while the consumer stalls. The user must write
// configuration registers only while the parser is idle; the parser does not enforce it.

module vtx_reply_frame_parser #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       bytes_wanted_o,
  output logic [1:0]       frame_status_o,
  output logic [7:0]       reply_command_o,
  output logic [15:0]      word_a_o,
  output logic [15:0]      word_b_o,
  output logic [15:0]      word_c_o,
  output logic [15:0]      word_d_o
);

  localparam logic [4:0] CK_POS  = 5'(FRAME_LEN - 2);
  localparam logic [4:0] LEN5    = 5'(FRAME_LEN);

  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_CMD  = 3'd1,
    PH_DATA = 3'd2,
    PH_CK   = 3'd3,
    PH_END  = 3'd4
  } phase_e;

  vtx_rfp_pkg::cfg_t cfg_q;

  phase_e      phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  cmd_q;
  logic [7:0]  ck_q;
  logic [7:0]  data_q [2:9];

  logic        in_acc;
  logic [4:0]  idx_inc;

  logic [4:0]  wanted_d;
  vtx_rfp_pkg::status_e status_d;
  logic [7:0]  cmd_out_d;
  logic [15:0] wa_d, wb_d, wc_d, wd_d;

  logic        out_valid_q;
  logic [4:0]  wanted_q;
  logic [1:0]  status_q;
  logic [7:0]  cmd_out_q;
  logic [15:0] wa_q, wb_q, wc_q, wd_q;

  vtx_rfp_pkg::verdict_t verdict;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_inc    = idx_q + 5'd1;

  vtx_rfp_judge u_judge (
    .cfg_i      (cfg_q),
    .cmd_i      (cmd_q),
    .end_byte_i (rx_byte_i),
    .checksum_i (ck_q),
    .sum_i      (sum_q),
    .byte2_i    (data_q[2]),
    .byte3_i    (data_q[3]),
    .byte6_i    (data_q[6]),
    .byte7_i    (data_q[7]),
    .verdict_o  (verdict)
  );

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    wanted_d  = 5'd1;
    status_d  = vtx_rfp_pkg::ST_NONE;
    cmd_out_d = 8'd0;
    wa_d      = 16'd0;
    wb_d      = 16'd0;
    wc_d      = 16'd0;
    wd_d      = 16'd0;
    case (phase_q)
      PH_CMD: begin
        if ((rx_byte_i == cfg_q.reset_code) || (rx_byte_i == cfg_q.settings_code) ||
            (rx_byte_i == cfg_q.temp_code)) begin
          sum_d    = rx_byte_i;
          idx_d    = 5'd2;
          phase_d  = PH_DATA;
          wanted_d = CK_POS;
        end else begin
          phase_d = PH_SYNC;
        end
      end
      PH_DATA: begin
        sum_d = sum_q + rx_byte_i;
        idx_d = idx_inc;
        if (idx_inc >= CK_POS) begin
          phase_d = PH_CK;
        end
        wanted_d = LEN5 - idx_inc;
      end
      PH_CK: begin
        phase_d = PH_END;
      end
      PH_END: begin
        phase_d   = PH_SYNC;
        cmd_out_d = cmd_q;
        status_d  = verdict.status;
        if (verdict.good) begin
          wanted_d = 5'd0;
          wa_d     = {data_q[3], data_q[2]};
          wb_d     = {data_q[5], data_q[4]};
          wc_d     = {data_q[7], data_q[6]};
          wd_d     = {data_q[9], data_q[8]};
        end
      end
      default: begin
        // unused codes behave as sync
        phase_d = (rx_byte_i == vtx_rfp_pkg::SYNC_BYTE) ? PH_CMD : PH_SYNC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_cmd  <= 8'd0;
      cfg_q.reset_code    <= 8'd114;
      cfg_q.settings_code <= 8'd118;
      cfg_q.temp_code     <= 8'd115;
      phase_q             <= PH_SYNC;
      idx_q               <= 5'd0;
      sum_q               <= 8'd0;
      out_valid_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vtx_rfp_pkg::CFG_EXPECTED_CMD:  cfg_q.expected_cmd  <= cfg_data_i;
          vtx_rfp_pkg::CFG_RESET_CODE:    cfg_q.reset_code    <= cfg_data_i;
          vtx_rfp_pkg::CFG_SETTINGS_CODE: cfg_q.settings_code <= cfg_data_i;
          vtx_rfp_pkg::CFG_TEMP_CODE:     cfg_q.temp_code     <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_q     <= phase_d;
        idx_q       <= idx_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame store and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if ((phase_q == PH_CMD) && (phase_d == PH_DATA)) begin
        cmd_q <= rx_byte_i;
      end
      if (phase_q == PH_DATA) begin
        for (int i = 2; i <= 9; i++) begin
          if (idx_q == 5'(i)) begin
            data_q[i] <= rx_byte_i;
          end
        end
      end
      if (phase_q == PH_CK) begin
        ck_q <= rx_byte_i;
      end
      wanted_q  <= wanted_d;
      status_q  <= status_d;
      cmd_out_q <= cmd_out_d;
      wa_q      <= wa_d;
      wb_q      <= wb_d;
      wc_q      <= wc_d;
      wd_q      <= wd_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bytes_wanted_o  = wanted_q;
  assign frame_status_o  = status_q;
  assign reply_command_o = cmd_out_q;
  assign word_a_o        = wa_q;
  assign word_b_o        = wb_q;
  assign word_c_o        = wc_q;
  assign word_d_o        = wd_q;

endmodule

`default_nettype wire

// ----- rtl/core/vtx_rfp_judge.sv -----
// Frame judgement on the end byte: end byte, checksum, command and echo test.
// Depends on vtx_rfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtx_rfp_judge (
  input  wire vtx_rfp_pkg::cfg_t     cfg_i,
  input  wire logic [7:0]            cmd_i,
  input  wire logic [7:0]            end_byte_i,
  input  wire logic [7:0]            checksum_i,
  input  wire logic [7:0]            sum_i,
  input  wire logic [7:0]            byte2_i,
  input  wire logic [7:0]            byte3_i,
  input  wire logic [7:0]            byte6_i,
  input  wire logic [7:0]            byte7_i,
  output vtx_rfp_pkg::verdict_t      verdict_o
);

  logic bad;
  logic echo;

  always_comb begin
    bad  = (end_byte_i != 8'd0) || (checksum_i != sum_i) || (cmd_i != cfg_i.expected_cmd);
    // an echo carries a zero payload in the command-specific bytes
    echo = (((cmd_i == cfg_i.reset_code) || (cmd_i == cfg_i.settings_code)) &&
            (byte2_i == 8'd0) && (byte3_i == 8'd0)) ||
           ((cmd_i == cfg_i.temp_code) && (byte6_i == 8'd0) && (byte7_i == 8'd0));
    verdict_o.good = 1'b0;
    if (bad) begin
      verdict_o.status = vtx_rfp_pkg::ST_INVALID;
    end else if (echo) begin
      verdict_o.status = vtx_rfp_pkg::ST_ECHO;
    end else begin
      verdict_o.status = vtx_rfp_pkg::ST_VALID;
      verdict_o.good   = 1'b1;
    end
  end

endmodule

`default_nettype wire
